### rtl/mvm_pkg.sv
// ----------------------------------------------------------------------------
// mvm_pkg
// Shared types and constants for the matrix-vector multiply block.
// ----------------------------------------------------------------------------
package mvm_pkg;

    localparam int DATA_W      = 32;
    localparam int ADDR_W      = 8;
    localparam int STORE_DEPTH = 256;
    localparam int SIZE_W      = 9;
    localparam int Q_DEPTH     = 4;
    localparam int Q_CNT_W     = 3;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_MATRIX = 1'b1;

    typedef struct packed {
        logic              is_load;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] value;
        logic              row_end;
        logic [ADDR_W-1:0] row_idx;
        logic              last_row;
    } op_t;

    typedef struct packed {
        logic [ADDR_W-1:0] row_index;
        logic [DATA_W-1:0] row_sum;
        logic              last_row;
    } res_t;

endpackage

### rtl/matrix_vector_multiply.sv
// ----------------------------------------------------------------------------
// matrix_vector_multiply
// Streaming square integer matrix times vector with a 256-entry vector store.
// ----------------------------------------------------------------------------
// Vector elements are loaded first, each at its column; a load also restarts
// the row and column counters. Matrix elements then follow in row-major order,
// and one result item leaves at the end of each row. The block sustains one
// item per clock cycle while no queue holds it back: the front end accepts an
// item each cycle while its four-entry queue is not full, and the back end
// issues one vector store access, one 32 by 32 multiply and one accumulate per
// cycle in a three-stage pipeline. A row result passes the store read and
// product registers before it is written to the output queue, and the back
// end stalls only when queued results plus staged operations reach four.
module matrix_vector_multiply (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic [mvm_pkg::SIZE_W-1:0]  cfg_data,
    input  logic                        push,
    output logic                        full,
    input  logic                        kind,
    input  logic [mvm_pkg::ADDR_W-1:0]  column_index,
    input  logic signed [mvm_pkg::DATA_W-1:0] value,
    output logic                        empty,
    input  logic                        pop,
    output logic [mvm_pkg::ADDR_W-1:0]  row_index,
    output logic signed [mvm_pkg::DATA_W-1:0] row_sum,
    output logic                        last_row
);
    import mvm_pkg::*;

    localparam int OP_W  = $bits(op_t);
    localparam int RES_W = $bits(res_t);

    logic               accept;
    op_t                front_op;
    op_t                back_op;
    logic [OP_W-1:0]    op_q_data;
    logic               op_q_empty;
    logic [Q_CNT_W-1:0] op_q_count;
    logic               op_take;
    logic               res_write;
    res_t               res_in;
    res_t               res_out;
    logic [RES_W-1:0]   res_q_data;
    logic [Q_CNT_W-1:0] res_count;
    logic               res_full;

    assign accept = push && !full;

    mvm_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .accept       (accept),
        .kind         (kind),
        .column_index (column_index),
        .value        (value),
        .op           (front_op)
    );

    mvm_fifo #(
        .WIDTH (OP_W),
        .DEPTH (Q_DEPTH)
    ) u_op_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept),
        .wr_data (front_op),
        .rd_en   (op_take),
        .rd_data (op_q_data),
        .count   (op_q_count),
        .full    (full),
        .empty   (op_q_empty)
    );

    assign back_op = op_t'(op_q_data);

    mvm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_avail  (!op_q_empty && (op_q_count != '0)),
        .op        (back_op),
        .op_take   (op_take),
        .res_count (res_count),
        .res_write (res_write),
        .res       (res_in)
    );

    mvm_fifo #(
        .WIDTH (RES_W),
        .DEPTH (Q_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_write && !res_full),
        .wr_data (res_in),
        .rd_en   (pop),
        .rd_data (res_q_data),
        .count   (res_count),
        .full    (res_full),
        .empty   (empty)
    );

    assign res_out   = res_t'(res_q_data);
    assign row_index = res_out.row_index;
    assign row_sum   = res_out.row_sum;
    assign last_row  = res_out.last_row;

endmodule

### rtl/mvm_fifo.sv
// ----------------------------------------------------------------------------
// mvm_fifo
// Small first-in first-out queue of packed items with a fill count.
// ----------------------------------------------------------------------------
module mvm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  logic [WIDTH-1:0]           wr_data,
    input  logic                       rd_en,
    output logic [WIDTH-1:0]           rd_data,
    output logic [$clog2(DEPTH+1)-1:0] count,
    output logic                       full,
    output logic                       empty
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH+1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### rtl/mvm_front.sv
// ----------------------------------------------------------------------------
// mvm_front
// Accepts items, keeps the row and column counters and turns each item into
// a load or multiply-accumulate operation for the back end.
// ----------------------------------------------------------------------------
module mvm_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write,
    input  logic [mvm_pkg::SIZE_W-1:0]   cfg_data,
    input  logic                         accept,
    input  logic                         kind,
    input  logic [mvm_pkg::ADDR_W-1:0]   column_index,
    input  logic [mvm_pkg::DATA_W-1:0]   value,
    output mvm_pkg::op_t                 op
);
    import mvm_pkg::*;

    logic [SIZE_W-1:0] size_reg;
    logic [ADDR_W-1:0] col_cnt_reg, col_cnt_next;
    logic [ADDR_W-1:0] row_cnt_reg, row_cnt_next;
    logic [ADDR_W-1:0] last_idx;
    logic              col_end;
    logic              row_last;

    always_comb
    begin
        if (size_reg == '0)
        begin
            last_idx = '0;
        end
        else if (size_reg[SIZE_W-1])
        begin
            last_idx = '1;
        end
        else
        begin
            last_idx = size_reg[ADDR_W-1:0] - 1'b1;
        end
    end

    assign col_end  = (col_cnt_reg >= last_idx);
    assign row_last = (row_cnt_reg >= last_idx);

    always_comb
    begin
        op.is_load  = (kind == KIND_LOAD);
        op.addr     = (kind == KIND_LOAD) ? column_index : col_cnt_reg;
        op.value    = value;
        op.row_end  = col_end;
        op.row_idx  = row_cnt_reg;
        op.last_row = row_last;

        col_cnt_next = col_cnt_reg;
        row_cnt_next = row_cnt_reg;
        if (accept)
        begin
            if (kind == KIND_LOAD)
            begin
                col_cnt_next = '0;
                row_cnt_next = '0;
            end
            else if (!col_end)
            begin
                col_cnt_next = col_cnt_reg + 1'b1;
            end
            else
            begin
                col_cnt_next = '0;
                row_cnt_next = row_last ? '0 : row_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg    <= SIZE_RESET;
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                size_reg <= cfg_data;
            end
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

endmodule

### rtl/mvm_back.sv
// ----------------------------------------------------------------------------
// mvm_back
// Executes operations: writes or reads the vector store, multiplies and
// accumulates, and writes a result at the end of each row.
// ----------------------------------------------------------------------------
module mvm_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          op_avail,
    input  mvm_pkg::op_t                  op,
    output logic                          op_take,
    input  logic [mvm_pkg::Q_CNT_W-1:0]   res_count,
    output logic                          res_write,
    output mvm_pkg::res_t                 res
);
    import mvm_pkg::*;

    logic [DATA_W-1:0] store_mem [STORE_DEPTH];
    logic [DATA_W-1:0] vec_rd_reg;

    logic              s1_valid_reg;
    op_t               s1_op_reg;

    logic              s2_valid_reg;
    op_t               s2_op_reg;
    logic [DATA_W-1:0] s2_prod_reg;

    logic [DATA_W-1:0] acc_reg, acc_next;
    logic [DATA_W-1:0] sum;
    logic [Q_CNT_W-1:0] in_flight;

    assign in_flight = res_count + Q_CNT_W'(s1_valid_reg) + Q_CNT_W'(s2_valid_reg);
    assign op_take   = op_avail && (in_flight < Q_CNT_W'(Q_DEPTH));

    always_ff @(posedge clk)
    begin
        if (op_take)
        begin
            if (op.is_load)
            begin
                store_mem[op.addr] <= op.value;
            end
            else
            begin
                vec_rd_reg <= store_mem[op.addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (op_take)
        begin
            s1_op_reg <= op;
        end
        if (s1_valid_reg)
        begin
            s2_op_reg   <= s1_op_reg;
            s2_prod_reg <= s1_op_reg.value * vec_rd_reg;
        end
    end

    assign sum = acc_reg + s2_prod_reg;

    always_comb
    begin
        acc_next      = acc_reg;
        res_write     = 1'b0;
        res.row_index = s2_op_reg.row_idx;
        res.row_sum   = sum;
        res.last_row  = s2_op_reg.last_row;
        if (s2_valid_reg)
        begin
            if (s2_op_reg.is_load)
            begin
                acc_next = '0;
            end
            else if (s2_op_reg.row_end)
            begin
                acc_next  = '0;
                res_write = 1'b1;
            end
            else
            begin
                acc_next = sum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            acc_reg      <= '0;
        end
        else
        begin
            s1_valid_reg <= op_take;
            s2_valid_reg <= s1_valid_reg;
            acc_reg      <= acc_next;
        end
    end

endmodule

### rtl/mvm_checker.sv
// ----------------------------------------------------------------------------
// mvm_checker
// Port-level checks on the result stream of the matrix-vector multiply block.
// ----------------------------------------------------------------------------
module mvm_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        empty,
    input logic                        pop,
    input logic [mvm_pkg::ADDR_W-1:0]  row_index,
    input logic signed [mvm_pkg::DATA_W-1:0] row_sum,
    input logic                        last_row
);
    import mvm_pkg::*;

    logic              have_prev_reg;
    logic              prev_last_reg;
    logic [ADDR_W-1:0] prev_row_reg;
    logic              res_taken;

    assign res_taken = pop && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_prev_reg <= 1'b0;
            prev_last_reg <= 1'b0;
            prev_row_reg  <= '0;
        end
        else if (res_taken)
        begin
            have_prev_reg <= 1'b1;
            prev_last_reg <= last_row;
            prev_row_reg  <= row_index;
        end
    end

    // A waiting result item holds its fields until it is taken.
    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(row_index) && $stable(row_sum)
                              && $stable(last_row)))
        else $error("result item changed while waiting");

    // Rows are reported in order, or restart at row zero.
    a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && have_prev_reg) |->
            (row_index == '0 || row_index == prev_row_reg + 1'b1))
        else $error("row index out of sequence");

    // The item after the last row always starts a new matrix.
    a_wrap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && have_prev_reg && prev_last_reg) |-> (row_index == '0))
        else $error("row index did not wrap after the last row");

endmodule

bind matrix_vector_multiply mvm_checker u_mvm_checker (.*);

### tb/matrix_vector_multiply_tb.sv
// ----------------------------------------------------------------------------
// matrix_vector_multiply_tb
// Self-checking testbench for the streaming matrix-vector multiply block.
// A short directed table covers the value extremes, the size corner cases,
// loads that restart a row, matrix wrap-around and a size change within a
// row. Random phases follow, each with its own size: vector loads and then
// row-major matrix items, with some broken sequences and noise mixed in.
// Every accepted item goes through a local predictor, and each row result
// popped from the block is compared field by field with the oldest
// prediction.
// ----------------------------------------------------------------------------
module matrix_vector_multiply_tb;

    import mvm_pkg::*;

    localparam int ITEM_TARGET   = 1300;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 300000;

    typedef enum logic {STEP_SIZE, STEP_ITEM} step_op_t;

    typedef struct {
        step_op_t          op;
        logic              item_kind;
        logic [ADDR_W-1:0] col;
        logic [DATA_W-1:0] val;
        bit                typed;
        res_t              want;
    } stim_row_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_write = 1'b0;
    logic [SIZE_W-1:0]        cfg_data = '0;
    logic                     push = 1'b0;
    logic                     full;
    logic                     kind = KIND_LOAD;
    logic [ADDR_W-1:0]        column_index = '0;
    logic signed [DATA_W-1:0] value = '0;
    logic                     empty;
    logic                     pop = 1'b0;
    logic [ADDR_W-1:0]        row_index;
    logic signed [DATA_W-1:0] row_sum;
    logic                     last_row;

    logic [DATA_W-1:0] vec_mem [STORE_DEPTH];
    bit                vec_written [STORE_DEPTH];
    logic [DATA_W-1:0] acc_model;
    logic [ADDR_W-1:0] col_model;
    logic [ADDR_W-1:0] row_model;
    logic [SIZE_W-1:0] size_model;

    res_t      pending_rows [$];
    stim_row_t stim_table [$];

    int mismatches = 0;
    int items_sent = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int pop_idle_pct = 0;
    int pop_gap = 0;
    int hold_left = 0;
    bit hold_pending = 1'b0;

    matrix_vector_multiply dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .push         (push),
        .full         (full),
        .kind         (kind),
        .column_index (column_index),
        .value        (value),
        .empty        (empty),
        .pop          (pop),
        .row_index    (row_index),
        .row_sum      (row_sum),
        .last_row     (last_row)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 100)
        begin
            $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
        end
    endtask

    function automatic int active_size(input logic [SIZE_W-1:0] s);
        if (s == '0)
        begin
            return 1;
        end
        if (s > STORE_DEPTH)
        begin
            return STORE_DEPTH;
        end
        return int'(s);
    endfunction

    function automatic bit dot_product_step(input logic k, input logic [ADDR_W-1:0] c,
                                            input logic [DATA_W-1:0] v, output res_t row_out);
        int                last_idx;
        logic [DATA_W-1:0] prod;
        logic              is_last;
        row_out = '0;
        if (k == KIND_LOAD)
        begin
            vec_mem[c] = v;
            vec_written[c] = 1'b1;
            acc_model = '0;
            col_model = '0;
            row_model = '0;
            return 1'b0;
        end
        last_idx = active_size(size_model) - 1;
        prod = v * vec_mem[col_model];
        acc_model = acc_model + prod;
        if (int'(col_model) < last_idx)
        begin
            col_model = col_model + 1'b1;
            return 1'b0;
        end
        is_last = (int'(row_model) >= last_idx);
        row_out.row_index = row_model;
        row_out.row_sum = acc_model;
        row_out.last_row = is_last;
        acc_model = '0;
        col_model = '0;
        row_model = is_last ? '0 : row_model + 1'b1;
        return 1'b1;
    endfunction

    function automatic logic [DATA_W-1:0] rand_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    function automatic stim_row_t mk(input step_op_t op, input logic k,
                                     input logic [ADDR_W-1:0] c, input logic [DATA_W-1:0] v,
                                     input bit chk, input logic [DATA_W-1:0] sum);
        stim_row_t r;
        r.op = op;
        r.item_kind = k;
        r.col = c;
        r.val = v;
        r.typed = chk;
        r.want.row_index = '0;
        r.want.row_sum = sum;
        r.want.last_row = 1'b1;
        return r;
    endfunction

    // A matrix item is never offered while the store entry it would read is
    // still unwritten; a load of column zero goes in its place.
    task automatic send_item(input logic k, input logic [ADDR_W-1:0] c,
                             input logic [DATA_W-1:0] v, input bit typed, input res_t typed_row);
        res_t got_row;
        bit   produced;
        if (k == KIND_MATRIX && !vec_written[col_model])
        begin
            k = KIND_LOAD;
            c = '0;
        end
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        push <= 1'b1;
        kind <= k;
        column_index <= c;
        value <= v;
        @(posedge clk);
        while (full) @(posedge clk);
        produced = dot_product_step(k, c, v, got_row);
        if (typed)
        begin
            pending_rows.push_back(typed_row);
        end
        else if (produced)
        begin
            pending_rows.push_back(got_row);
        end
        items_sent++;
    endtask

    task automatic write_size(input logic [SIZE_W-1:0] s);
        push <= 1'b0;
        while (pending_rows.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data <= s;
        @(posedge clk);
        cfg_write <= 1'b0;
        size_model = s;
    endtask

    always @(posedge clk)
    begin : pop_side
        res_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_rows.size() == 0)
            begin
                report_mismatch($sformatf("unexpected row result, row_index %0d", row_index));
            end
            else
            begin
                want = pending_rows.pop_front();
                if (row_index !== want.row_index)
                begin
                    report_mismatch($sformatf("row_index got %0d want %0d",
                                              row_index, want.row_index));
                end
                if (row_sum !== want.row_sum)
                begin
                    report_mismatch($sformatf("row_sum got %h want %h (row %0d)",
                                              row_sum, want.row_sum, want.row_index));
                end
                if (last_row !== want.last_row)
                begin
                    report_mismatch($sformatf("last_row got %b want %b (row %0d)",
                                              last_row, want.last_row, want.row_index));
                end
            end
        end
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else if (hold_pending)
        begin
            hold_pending = 1'b0;
            hold_left = HOLD_CYCLES;
            pop <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            pop <= 1'b0;
        end
        else if (pop_gap > 0)
        begin
            pop_gap--;
            pop <= 1'b0;
        end
        else if (pop_idle_pct != 0 && $urandom_range(0, 99) < pop_idle_pct)
        begin
            pop_gap = $urandom_range(1, 7) - 1;
            pop <= 1'b0;
        end
        else
        begin
            pop <= 1'b1;
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin : stimulus
        int                phase;
        int                n;
        int                budget;
        int                phase_end;
        int                rows;
        int                count;
        int                j;
        bit                descending;
        logic [SIZE_W-1:0] size_cfg;

        stim_table.push_back(mk(STEP_SIZE, KIND_LOAD,   8'd0,   32'd1,         1'b0, 32'd0));
        stim_table.push_back(mk(STEP_ITEM, KIND_LOAD,   8'd0,   32'hFFFF_FFFF, 1'b0, 32'd0));
        stim_table.push_back(mk(STEP_ITEM, KIND_MATRIX, 8'd0,   32'h8000_0000, 1'b1,
                                32'h8000_0000));
        stim_table.push_back(mk(STEP_ITEM, KIND_MATRIX, 8'hFF,  32'h7FFF_FFFF, 1'b1,
                                32'h8000_0001));
        stim_table.push_back(mk(STEP_ITEM, KIND_LOAD,   8'd0,   32'h7FFF_FFFF, 1'b0, 32'd0));
        stim_table.push_back(mk(STEP_ITEM, KIND_MATRIX, 8'd0,   32'h7FFF_FFFF, 1'b1,
                                32'h0000_0001));
        stim_table.push_back(mk(STEP_ITEM, KIND_LOAD,   8'hFF,  32'h1234_5678, 1'b0, 32'd0));
        stim_table.push_back(mk(STEP_ITEM, KIND_MATRIX, 8'h55,  32'd2,         1'b1,
                                32'hFFFF_FFFE));
        stim_table.push_back(mk(STEP_SIZE, KIND_LOAD,   8'd0,   32'd0,         1'b0, 32'd0));
        stim_table.push_back(mk(STEP_ITEM, KIND_MATRIX, 8'd0,   32'd1,         1'b1,
                                32'h7FFF_FFFF));
        stim_table.push_back(mk(STEP_SIZE, KIND_LOAD,   8'd0,   32'd2,         1'b0, 32'd0));
        stim_table.push_back(mk(STEP_ITEM, KIND_LOAD,   8'd0,   32'd1,         1'b0, 32'd0));
        stim_table.push_back(mk(STEP_ITEM, KIND_LOAD,   8'd1,   32'd16,        1'b0, 32'd0));
        stim_table.push_back(mk(STEP_ITEM, KIND_MATRIX, 8'd0,   32'd5,         1'b0, 32'd0));
        stim_table.push_back(mk(STEP_ITEM, KIND_MATRIX, 8'hAA,  32'd3,         1'b0, 32'd0));
        stim_table.push_back(mk(STEP_ITEM, KIND_MATRIX, 8'd0,   32'd1,         1'b0, 32'd0));
        stim_table.push_back(mk(STEP_ITEM, KIND_MATRIX, 8'd0,   32'd1,         1'b0, 32'd0));
        stim_table.push_back(mk(STEP_ITEM, KIND_MATRIX, 8'd0,   32'd2,         1'b0, 32'd0));
        stim_table.push_back(mk(STEP_ITEM, KIND_LOAD,   8'd1,   32'd2,         1'b0, 32'd0));
        stim_table.push_back(mk(STEP_ITEM, KIND_MATRIX, 8'd0,   32'd7,         1'b0, 32'd0));
        stim_table.push_back(mk(STEP_ITEM, KIND_MATRIX, 8'd0,   32'd1,         1'b0, 32'd0));
        stim_table.push_back(mk(STEP_ITEM, KIND_MATRIX, 8'd0,   32'd4,         1'b0, 32'd0));
        stim_table.push_back(mk(STEP_ITEM, KIND_MATRIX, 8'd0,   32'd0,         1'b0, 32'd0));
        stim_table.push_back(mk(STEP_ITEM, KIND_MATRIX, 8'd0,   32'd1,         1'b0, 32'd0));
        stim_table.push_back(mk(STEP_ITEM, KIND_MATRIX, 8'd0,   32'd1,         1'b0, 32'd0));
        stim_table.push_back(mk(STEP_ITEM, KIND_MATRIX, 8'd0,   32'd5,         1'b0, 32'd0));
        stim_table.push_back(mk(STEP_SIZE, KIND_LOAD,   8'd0,   32'd1,         1'b0, 32'd0));
        stim_table.push_back(mk(STEP_ITEM, KIND_MATRIX, 8'd0,   32'd3,         1'b0, 32'd0));

        size_model = SIZE_RESET;
        acc_model = '0;
        col_model = '0;
        row_model = '0;
        foreach (vec_written[i])
        begin
            vec_written[i] = 1'b0;
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 20;
        pop_idle_pct = 20;

        foreach (stim_table[i])
        begin
            if (stim_table[i].op == STEP_SIZE)
            begin
                write_size(stim_table[i].val[SIZE_W-1:0]);
            end
            else
            begin
                send_item(stim_table[i].item_kind, stim_table[i].col, stim_table[i].val,
                          stim_table[i].typed, stim_table[i].want);
            end
        end

        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            case (phase)
                0: size_cfg = 9'd1;
                1: size_cfg = 9'd0;
                2: size_cfg = 9'd256;
                3: size_cfg = 9'd300;
                4: size_cfg = 9'd511;
                default:
                    size_cfg = ($urandom_range(0, 5) == 0) ? SIZE_W'($urandom_range(10, 32))
                                                           : SIZE_W'($urandom_range(1, 9));
            endcase
            case (phase)
                2: budget = 560;
                3, 4: budget = 50;
                default: budget = $urandom_range(40, 120);
            endcase
            write_size(size_cfg);
            if (items_sent >= ITEM_TARGET - 200)
            begin
                send_idle_pct = 0;
                pop_idle_pct = 0;
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0: send_idle_pct = 0;
                    1: send_idle_pct = 10;
                    default: send_idle_pct = 30;
                endcase
                case ($urandom_range(0, 3))
                    0: pop_idle_pct = 0;
                    1: pop_idle_pct = 10;
                    2: pop_idle_pct = 30;
                    default: pop_idle_pct = 60;
                endcase
            end
            if (phase == 0)
            begin
                // The output side holds off while items keep coming.
                send_idle_pct = 0;
                hold_pending = 1'b1;
            end
            n = active_size(size_cfg);
            phase_end = items_sent + budget;

            // Carry on the previous stream with the row and column counters
            // as they stand.
            if ($urandom_range(0, 1) == 1)
            begin
                repeat ($urandom_range(1, 5))
                begin
                    send_item(KIND_MATRIX, ADDR_W'($urandom), rand_value(), 1'b0, '0);
                end
            end

            while (items_sent < phase_end)
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    send_item(1'($urandom_range(0, 1)), ADDR_W'($urandom), rand_value(),
                              1'b0, '0);
                end
                else
                begin
                    descending = 1'($urandom_range(0, 1));
                    for (j = 0; j < n && items_sent < phase_end; j++)
                    begin
                        send_item(KIND_LOAD, ADDR_W'(descending ? n - 1 - j : j), rand_value(),
                                  1'b0, '0);
                    end
                    if ($urandom_range(0, 3) == 0)
                    begin
                        send_item(KIND_LOAD, ADDR_W'($urandom), rand_value(), 1'b0, '0);
                    end
                    if (n <= 8)
                    begin
                        rows = $urandom_range(1, 2 * n + 1);
                    end
                    else if (n <= 32)
                    begin
                        rows = $urandom_range(1, 3);
                    end
                    else
                    begin
                        rows = 1;
                    end
                    count = rows * n;
                    if ($urandom_range(0, 3) == 0)
                    begin
                        count = $urandom_range(1, count);
                    end
                    for (j = 0; j < count && items_sent < phase_end; j++)
                    begin
                        send_item(KIND_MATRIX, ADDR_W'($urandom), rand_value(), 1'b0, '0);
                    end
                end
            end
            phase++;
        end

        push <= 1'b0;
        while (pending_rows.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES + 4) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
